[hdl/rbq_pkg.sv]
// rbq_pkg: shared types and constants for the reorder block queue
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package rbq_pkg;

  localparam int POOL_DEPTH = 16;
  localparam int IDX_W      = $clog2(POOL_DEPTH);
  localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
  localparam int CFG_W      = 5;
  localparam int THR_W      = CFG_W + 2;

  localparam logic [CFG_W-1:0] POOL_SIZE_RST    = CFG_W'(16);
  localparam logic [CFG_W-1:0] EVICT_MARGIN_RST = CFG_W'(2);

  // configuration register indexes, selected by paddr[2]
  localparam logic REG_POOL_SIZE    = 1'b0;
  localparam logic REG_EVICT_MARGIN = 1'b1;

  typedef enum logic [2:0] {
    OP_REQUEST = 3'd0,
    OP_READY   = 3'd1,
    OP_RELEASE = 3'd2,
    OP_POP     = 3'd3,
    OP_TOP     = 3'd4,
    OP_RESET   = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_NO_FREE    = 2'd1,
    STAT_NOT_QUEUED = 2'd2,
    STAT_EMPTY      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    BLK_FREE  = 2'd0,
    BLK_INUSE = 2'd1,
    BLK_READY = 2'd2
  } blk_state_t;

  typedef enum logic {
    S_IDLE  = 1'b0,
    S_EVICT = 1'b1
  } fsm_t;

  // control for one queue cell
  typedef struct packed {
    logic             shift;
    logic             load;
    logic [IDX_W-1:0] data;
  } cell_ctl_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] blk;
    status_t          status;
    logic [CNT_W-1:0] evnow;
    logic [CNT_W-1:0] queued;
    logic [CNT_W-1:0] inuse;
    logic [CNT_W-1:0] evtotal;
  } result_t;

endpackage

`default_nettype wire

[hdl/rbq_cell.sv]
// rbq_cell: one slot of the in-order queue, shifts toward the head
// depends on rbq_pkg
`timescale 1ns / 1ps
`default_nettype none

module rbq_cell
  import rbq_pkg::*;
(
  input  wire logic             clk,
  input  wire cell_ctl_t        ctl,
  input  wire logic [IDX_W-1:0] next_data,
  output logic      [IDX_W-1:0] data
);

  logic [IDX_W-1:0] data_r;
  logic [IDX_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl.shift) begin
      data_nxt = next_data;
    end else if (ctl.load) begin
      data_nxt = ctl.data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

`default_nettype wire

[hdl/rbq_ctrl.sv]
// rbq_ctrl: block tables, counters, eviction sequencer and result register
// depends on rbq_pkg; drives the rbq_cell chain
`timescale 1ns / 1ps
`default_nettype none

module rbq_ctrl
  import rbq_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [CFG_W-1:0]     pool_size,
  input  wire logic [CFG_W-1:0]     evict_margin,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [2:0]           in_op,
  input  wire logic [IDX_W-1:0]     in_blk,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output result_t                   out_res,
  input  wire logic [IDX_W-1:0]     head,
  output cell_ctl_t [POOL_DEPTH-1:0] cell_ctl
);

  fsm_t                         state_r, state_nxt;
  blk_state_t [POOL_DEPTH-1:0]  st_r, st_nxt;
  logic       [POOL_DEPTH-1:0]  q_r, q_nxt;
  logic [CNT_W-1:0]             len_r, len_nxt;
  logic [CNT_W-1:0]             evc_r, evc_nxt;
  logic [CNT_W-1:0]             alloc_r, alloc_nxt;
  logic [CNT_W-1:0]             evnow_r, evnow_nxt;
  logic                         out_valid_r, out_valid_nxt;
  result_t                      out_res_r, out_res_nxt;

  logic [CNT_W-1:0] n;
  logic             head_rdy;
  logic             found;
  logic [IDX_W-1:0] free_idx;
  logic             drop;
  logic             append;
  logic             emit;
  logic             res_valid;
  logic [IDX_W-1:0] res_blk;
  status_t          res_status;
  logic [CNT_W-1:0] res_evnow;
  logic             accept;
  logic             bi_in_range;
  logic             threshold;

  assign n = (pool_size < CFG_W'(POOL_DEPTH)) ? CNT_W'(pool_size) : CNT_W'(POOL_DEPTH);
  assign head_rdy = (len_r != '0) && (st_r[head] == BLK_READY);
  assign bi_in_range = CNT_W'(in_blk) < n;
  assign threshold = (THR_W'(len_r) + THR_W'(evc_r) + THR_W'(evict_margin))
                     >= THR_W'(pool_size);

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  // lowest free block that is not still sitting in the queue
  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int i = 0; i < POOL_DEPTH; i++) begin
      if (!found && (CNT_W'(i) < n) && (st_r[i] == BLK_FREE) && !q_r[i]) begin
        found    = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt  = state_r;
    st_nxt     = st_r;
    q_nxt      = q_r;
    len_nxt    = len_r;
    evc_nxt    = evc_r;
    alloc_nxt  = alloc_r;
    evnow_nxt  = evnow_r;
    drop       = 1'b0;
    append     = 1'b0;
    emit       = 1'b0;
    res_valid  = 1'b0;
    res_blk    = '0;
    res_status = STAT_OK;
    res_evnow  = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          emit = 1'b1;
          case (in_op)
            OP_REQUEST: begin
              if ((len_r < n) && found) begin
                st_nxt[free_idx] = BLK_INUSE;
                q_nxt[free_idx]  = 1'b1;
                append           = 1'b1;
                len_nxt          = len_r + 1'b1;
                alloc_nxt        = alloc_r + 1'b1;
                res_valid        = 1'b1;
                res_blk          = free_idx;
              end else begin
                res_status = STAT_NO_FREE;
              end
            end
            OP_READY: begin
              if (bi_in_range && q_r[in_blk] && (st_r[in_blk] != BLK_FREE)) begin
                st_nxt[in_blk] = BLK_READY;
              end else begin
                res_status = STAT_NOT_QUEUED;
              end
            end
            OP_RELEASE: begin
              if (bi_in_range && (st_r[in_blk] != BLK_FREE)) begin
                st_nxt[in_blk] = BLK_FREE;
                if (alloc_r != '0) begin
                  alloc_nxt = alloc_r - 1'b1;
                end
              end
            end
            OP_POP: begin
              if (len_r == '0) begin
                res_status = STAT_EMPTY;
              end else if (head_rdy) begin
                res_valid = 1'b1;
                res_blk   = head;
                drop      = 1'b1;
              end else if (threshold) begin
                // result comes out of the eviction walk
                emit      = 1'b0;
                evnow_nxt = '0;
                state_nxt = S_EVICT;
              end else begin
                res_status = STAT_EMPTY;
              end
            end
            OP_TOP: begin
              if (len_r != '0) begin
                res_valid  = 1'b1;
                res_blk    = head;
                res_status = head_rdy ? STAT_OK : STAT_EMPTY;
              end else begin
                res_status = STAT_EMPTY;
              end
            end
            OP_RESET: begin
              st_nxt    = {POOL_DEPTH{BLK_FREE}};
              q_nxt     = '0;
              len_nxt   = '0;
              evc_nxt   = '0;
              alloc_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_EVICT: begin
        if ((len_r != '0) && !head_rdy) begin
          drop      = 1'b1;
          evnow_nxt = evnow_r + 1'b1;
          if (evc_r < n) begin
            evc_nxt = evc_r + 1'b1;
          end
        end else begin
          emit      = 1'b1;
          res_evnow = evnow_r;
          state_nxt = S_IDLE;
          if (head_rdy) begin
            res_valid = 1'b1;
            res_blk   = head;
            drop      = 1'b1;
          end else begin
            res_status = STAT_EMPTY;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (drop) begin
      q_nxt[head] = 1'b0;
      len_nxt     = len_nxt - 1'b1;
    end

    out_valid_nxt = out_valid_r && !out_ready;
    out_res_nxt   = out_res_r;
    if (emit) begin
      out_valid_nxt       = 1'b1;
      out_res_nxt.valid   = res_valid;
      out_res_nxt.blk     = res_blk;
      out_res_nxt.status  = res_status;
      out_res_nxt.evnow   = res_evnow;
      out_res_nxt.queued  = len_nxt;
      out_res_nxt.inuse   = alloc_nxt;
      out_res_nxt.evtotal = evc_nxt;
    end
  end

  // tail write lands on the cell at the current length
  always_comb begin
    for (int i = 0; i < POOL_DEPTH; i++) begin
      cell_ctl[i].shift = drop;
      cell_ctl[i].load  = append && (len_r[IDX_W-1:0] == IDX_W'(i));
      cell_ctl[i].data  = free_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      st_r        <= {POOL_DEPTH{BLK_FREE}};
      q_r         <= '0;
      len_r       <= '0;
      evc_r       <= '0;
      alloc_r     <= '0;
      evnow_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      st_r        <= st_nxt;
      q_r         <= q_nxt;
      len_r       <= len_nxt;
      evc_r       <= evc_nxt;
      alloc_r     <= alloc_nxt;
      evnow_r     <= evnow_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

`default_nettype wire

[hdl/reorder_block_queue_unit.sv]
// reorder_block_queue_unit: top level, config registers, control and queue cell chain
// depends on rbq_pkg, rbq_ctrl, rbq_cell
//
//   group   dir   payload
//   in_     in    tdata: opcode, block_index
//   out_    out   tuser: result_valid; tdata: result block, status and counters
//   cfg_    in    pool_size at 0x0, evict_margin at 0x4
//
// most transactions are answered by a result registered at the accepting edge
// a pop that evicts not-ready heads does so in the evict state, one queue shift
// per cycle through the cell chain, then registers its result
// synchronous active-low reset frees every block and empties the queue
// a waiting result does not block the next transaction when out_tready is high
`timescale 1ns / 1ps
`default_nettype none

module reorder_block_queue_unit
  import rbq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [2:0] opcode, [6:3] block_index, [7] zero
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [3:0] result_block, [5:4] status,
                                       // [10:6] evicted_now, [15:11] queued_count,
                                       // [20:16] inuse_count, [25:21] evicted_total
  output logic             out_tuser,  // [0] result_valid
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic [CFG_W-1:0] pool_size_r, pool_size_nxt;
  logic [CFG_W-1:0] evict_margin_r, evict_margin_nxt;
  logic             cfg_wr;

  cell_ctl_t [POOL_DEPTH-1:0] cell_ctl;
  logic [POOL_DEPTH-1:0][IDX_W-1:0] cell_data;
  result_t res;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    pool_size_nxt    = pool_size_r;
    evict_margin_nxt = evict_margin_r;
    if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_POOL_SIZE:    pool_size_nxt    = cfg_pwdata[CFG_W-1:0];
        REG_EVICT_MARGIN: evict_margin_nxt = cfg_pwdata[CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_POOL_SIZE:    cfg_prdata = 32'(pool_size_r);
      REG_EVICT_MARGIN: cfg_prdata = 32'(evict_margin_r);
      default:          cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_size_r    <= POOL_SIZE_RST;
      evict_margin_r <= EVICT_MARGIN_RST;
    end else begin
      pool_size_r    <= pool_size_nxt;
      evict_margin_r <= evict_margin_nxt;
    end
  end

  rbq_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .pool_size    (pool_size_r),
    .evict_margin (evict_margin_r),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_op        (in_tdata[2:0]),
    .in_blk       (in_tdata[6:3]),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_res      (res),
    .head         (cell_data[0]),
    .cell_ctl     (cell_ctl)
  );

  // head sits in cell 0; each cell takes its upper neighbor on a shift
  for (genvar g = 0; g < POOL_DEPTH; g++) begin : g_cell
    if (g == POOL_DEPTH - 1) begin : g_last
      rbq_cell u_cell (
        .clk       (clk),
        .ctl       (cell_ctl[g]),
        .next_data ('0),
        .data      (cell_data[g])
      );
    end else begin : g_mid
      rbq_cell u_cell (
        .clk       (clk),
        .ctl       (cell_ctl[g]),
        .next_data (cell_data[g+1]),
        .data      (cell_data[g])
      );
    end
  end

  assign out_tuser = res.valid;
  assign out_tdata = {6'b0, res.evtotal, res.inuse, res.queued, res.evnow,
                      res.status, res.blk};

endmodule

`default_nettype wire
